// File: sv/uartrf_pkg.sv
package uartrf_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RX    = 2'd2,
    OP_MODEM = 2'd3
  } opcode_e;

  // Register offsets
  localparam logic [2:0] ADDR_DATA = 3'd0;
  localparam logic [2:0] ADDR_IER  = 3'd1;
  localparam logic [2:0] ADDR_IIR  = 3'd2;
  localparam logic [2:0] ADDR_LCR  = 3'd3;
  localparam logic [2:0] ADDR_MCR  = 3'd4;
  localparam logic [2:0] ADDR_LSR  = 3'd5;
  localparam logic [2:0] ADDR_MSR  = 3'd6;
  localparam logic [2:0] ADDR_SCR  = 3'd7;

  // Interrupt identification codes
  localparam logic [2:0] IID_NONE  = 3'd1;
  localparam logic [2:0] IID_THRE  = 3'd2;
  localparam logic [2:0] IID_RDATA = 3'd4;
  localparam logic [2:0] IID_MODEM = 3'd6;

  // Register bits and reset values
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned MCR_LOOP_BIT = 4;
  localparam int unsigned LSR_DR_BIT   = 0;
  localparam int unsigned LSR_THRE_BIT = 5;
  localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;
  localparam logic [7:0] LSR_DR_BI     = 8'h11;
  localparam logic [7:0] LSR_RESET     = 8'h60;
  localparam logic [7:0] MSR_RESET     = 8'hB0;
  localparam logic [7:0] MSR_LINES     = 8'hF0;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    opcode_e    opcode;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic [3:0] modem_lines;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_accepted;
    logic        rts_out;
    logic        dtr_out;
    logic [15:0] baud_divisor;
    logic [7:0]  line_format;
  } result_t;

  // Fixed-priority interrupt identification
  function automatic logic [2:0] ident(input logic data_ready, input logic tx_pending,
                                       input logic modem_chg, input logic [3:0] ier);
    logic [2:0] id;
    if (data_ready && ier[0]) begin
      id = IID_RDATA;
    end else if (tx_pending && ier[1]) begin
      id = IID_THRE;
    end else if (modem_chg && ier[2]) begin
      id = IID_MODEM;
    end else begin
      id = IID_NONE;
    end
    return id;
  endfunction

endpackage

// File: sv/uartrf_core.sv
module uartrf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  uartrf_pkg::item_t  item_i,
  output uartrf_pkg::result_t result_o
);

  logic [15:0] dl_q, dl_d;
  logic [7:0]  rbr_q, rbr_d;
  logic [3:0]  ier_q, ier_d;
  logic [2:0]  iir_q, iir_d;
  logic [7:0]  lcr_q, lcr_d;
  logic [4:0]  mcr_q, mcr_d;
  logic [7:0]  lsr_q, lsr_d;
  logic [7:0]  msr_q, msr_d;
  logic [7:0]  scr_q, scr_d;
  logic        txp_q, txp_d;
  logic        mchg_q, mchg_d;
  logic        reident;
  logic        dlab;
  logic        loopback;
  logic [7:0]  rd_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        rx_acc;
  logic [7:0]  msr_new;

  assign dlab     = lcr_q[uartrf_pkg::LCR_DLAB_BIT];
  assign loopback = mcr_q[uartrf_pkg::MCR_LOOP_BIT];

  // New modem status: line levels on top, deltas below (RI on its trailing edge)
  assign msr_new = {item_i.modem_lines[3], item_i.modem_lines[2],
                    item_i.modem_lines[1], item_i.modem_lines[0],
                    item_i.modem_lines[3] ^ msr_q[7],
                    ~item_i.modem_lines[2] & msr_q[6],
                    item_i.modem_lines[1] ^ msr_q[5],
                    item_i.modem_lines[0] ^ msr_q[4]};

  // Decode one item into next register values and result bytes
  always_comb begin
    dl_d     = dl_q;
    rbr_d    = rbr_q;
    ier_d    = ier_q;
    lcr_d    = lcr_q;
    mcr_d    = mcr_q;
    lsr_d    = lsr_q;
    msr_d    = msr_q;
    scr_d    = scr_q;
    txp_d    = txp_q;
    mchg_d   = mchg_q;
    reident  = 1'b0;
    rd_data  = 8'h00;
    tx_valid = 1'b0;
    tx_byte  = 8'h00;
    rx_acc   = 1'b0;
    unique case (item_i.opcode)
      uartrf_pkg::OP_WRITE: begin
        unique case (item_i.reg_addr)
          uartrf_pkg::ADDR_DATA: begin
            if (dlab) begin
              dl_d = {dl_q[15:8], item_i.write_data};
            end else begin
              tx_valid = 1'b1;
              tx_byte  = item_i.write_data;
              txp_d    = 1'b1;
              lsr_d    = lsr_q | uartrf_pkg::LSR_TX_EMPTY;
              reident  = 1'b1;
            end
          end
          uartrf_pkg::ADDR_IER: begin
            if (dlab) begin
              dl_d = {item_i.write_data, dl_q[7:0]};
            end else begin
              ier_d = item_i.write_data[3:0];
              if (lsr_q[uartrf_pkg::LSR_THRE_BIT]) begin
                txp_d = 1'b1;
              end
              reident = 1'b1;
            end
          end
          uartrf_pkg::ADDR_LCR: lcr_d = item_i.write_data;
          uartrf_pkg::ADDR_MCR: mcr_d = item_i.write_data[4:0];
          uartrf_pkg::ADDR_SCR: scr_d = item_i.write_data;
          default: ;
        endcase
      end
      uartrf_pkg::OP_READ: begin
        unique case (item_i.reg_addr)
          uartrf_pkg::ADDR_DATA: begin
            if (dlab) begin
              rd_data = dl_q[7:0];
            end else begin
              rd_data = rbr_q;
              lsr_d   = lsr_q & ~uartrf_pkg::LSR_DR_BI;
              reident = 1'b1;
            end
          end
          uartrf_pkg::ADDR_IER: rd_data = dlab ? dl_q[15:8] : {4'b0000, ier_q};
          uartrf_pkg::ADDR_IIR: begin
            rd_data = {5'b00000, iir_q};
            if (iir_q == uartrf_pkg::IID_THRE) begin
              txp_d = 1'b0;
            end
            reident = 1'b1;
          end
          uartrf_pkg::ADDR_LCR: rd_data = lcr_q;
          uartrf_pkg::ADDR_MCR: rd_data = {3'b000, mcr_q};
          uartrf_pkg::ADDR_LSR: rd_data = lsr_q;
          uartrf_pkg::ADDR_MSR: begin
            if (loopback) begin
              rd_data = {mcr_q[3:2], mcr_q[0], mcr_q[1], 4'b0000};
            end else begin
              rd_data = msr_q;
              msr_d   = msr_q & uartrf_pkg::MSR_LINES;
              mchg_d  = 1'b0;
              reident = 1'b1;
            end
          end
          default: rd_data = scr_q;
        endcase
      end
      uartrf_pkg::OP_RX: begin
        // Drop the byte while earlier data is unread
        if (!lsr_q[uartrf_pkg::LSR_DR_BIT]) begin
          rbr_d   = item_i.rx_byte;
          lsr_d   = lsr_q | 8'h01;
          reident = 1'b1;
          rx_acc  = 1'b1;
        end
      end
      uartrf_pkg::OP_MODEM: begin
        msr_d   = msr_new;
        mchg_d  = 1'b1;
        reident = 1'b1;
      end
      default: ;
    endcase
    iir_d = reident ? uartrf_pkg::ident(lsr_d[uartrf_pkg::LSR_DR_BIT], txp_d, mchg_d, ier_d)
                    : iir_q;
  end

  // Result of the item as it leaves the register file
  always_comb begin
    result_o.read_data    = rd_data;
    result_o.irq_level    = (iir_d != uartrf_pkg::IID_NONE);
    result_o.tx_valid     = tx_valid;
    result_o.tx_byte      = tx_byte;
    result_o.rx_accepted  = rx_acc;
    result_o.rts_out      = mcr_d[1];
    result_o.dtr_out      = mcr_d[0];
    result_o.baud_divisor = dl_d;
    result_o.line_format  = lcr_d;
  end

  // Commit register state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q   <= '0;
      rbr_q  <= '0;
      ier_q  <= '0;
      iir_q  <= uartrf_pkg::IID_NONE;
      lcr_q  <= '0;
      mcr_q  <= '0;
      lsr_q  <= uartrf_pkg::LSR_RESET;
      msr_q  <= uartrf_pkg::MSR_RESET;
      scr_q  <= '0;
      txp_q  <= 1'b0;
      mchg_q <= 1'b0;
    end else if (accept_i) begin
      dl_q   <= dl_d;
      rbr_q  <= rbr_d;
      ier_q  <= ier_d;
      iir_q  <= iir_d;
      lcr_q  <= lcr_d;
      mcr_q  <= mcr_d;
      lsr_q  <= lsr_d;
      msr_q  <= msr_d;
      scr_q  <= scr_d;
      txp_q  <= txp_d;
      mchg_q <= mchg_d;
    end
  end

endmodule

// File: sv/uart_16450_register_file_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata item fields
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata result fields
//
// One word per cycle in while s_axis_tready is high, one result word per input word out.
// Register state updates at the edge that takes a word, which also registers its result.
// An output register plus one skid entry keep input taken while the output is stalled;
// s_axis_tready drops only while both hold results.
// Reset clears all registers to their power-on values and empties the output stage.
module uart_16450_register_file_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] opcode
  input  logic [1:0]                         s_axis_tuser,
  // [2:0] reg_addr, [10:3] write_data, [18:11] rx_byte, [22:19] modem_lines, [23] zero
  input  logic [uartrf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] read_data, [8] irq_level, [9] tx_valid, [17:10] tx_byte, [18] rx_accepted,
  // [19] rts_out, [20] dtr_out, [36:21] baud_divisor, [44:37] line_format, [47:45] zero
  output logic [uartrf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  uartrf_pkg::item_t   item;
  uartrf_pkg::result_t result;
  logic                accept;
  logic                out_free;
  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  uartrf_pkg::result_t out_q, out_d;
  uartrf_pkg::result_t skid_q, skid_d;

  // Unpack the input word
  assign item.opcode      = uartrf_pkg::opcode_e'(s_axis_tuser);
  assign item.reg_addr    = s_axis_tdata[2:0];
  assign item.write_data  = s_axis_tdata[10:3];
  assign item.rx_byte     = s_axis_tdata[18:11];
  assign item.modem_lines = s_axis_tdata[22:19];

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  uartrf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .result_o (result)
  );

  // Advance the output register and the skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_d       = result;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Pack the result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.line_format, out_q.baud_divisor, out_q.dtr_out,
                          out_q.rts_out, out_q.rx_accepted, out_q.tx_byte, out_q.tx_valid,
                          out_q.irq_level, out_q.read_data};

endmodule

// File: sv/uartrf_checker.sv
module uartrf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [uartrf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Input backs up only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A transmitted byte comes only from a write, so no read data with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'h00 && !m_axis_tdata[18])
    else $error("tx byte alongside read or rx result");

  // A zero tx_valid carries a zero tx byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[17:10] == 8'h00)
    else $error("tx byte without tx_valid");

endmodule

bind uart_16450_register_file_top uartrf_checker u_uartrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/uart_16450_register_file_checker.sv
module uart_16450_register_file_checker
  import uartrf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [1:0] opcode
  input  logic [1:0]             s_axis_tuser,
  // [2:0] reg_addr, [10:3] write_data, [18:11] rx_byte, [22:19] modem_lines, [23] zero
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_data, [8] irq_level, [9] tx_valid, [17:10] tx_byte, [18] rx_accepted,
  // [19] rts_out, [20] dtr_out, [36:21] baud_divisor, [44:37] line_format, [47:45] zero
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output int                     fail_count_o,
  output int                     pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Register file copy tracked alongside the block
  logic [15:0] div_latch;
  logic [7:0]  rx_buf;
  logic [3:0]  ier_q;
  logic [2:0]  iir_q;
  logic [7:0]  lcr_q;
  logic [4:0]  mcr_q;
  logic [7:0]  lsr_q;
  logic [7:0]  msr_q;
  logic [7:0]  scr_q;
  logic        thre_pending;
  logic        modem_chg_seen;

  result_t expected_results[$];

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    fail_count_o++;
  endtask

  // Fixed priority: received data, then transmit empty, then modem change
  function automatic void refresh_ident();
    if (lsr_q[LSR_DR_BIT] && ier_q[0]) begin
      iir_q = IID_RDATA;
    end else if (thre_pending && ier_q[1]) begin
      iir_q = IID_THRE;
    end else if (modem_chg_seen && ier_q[2]) begin
      iir_q = IID_MODEM;
    end else begin
      iir_q = IID_NONE;
    end
  endfunction

  // Apply one word to the register copy and build the result it should produce
  task automatic predict_uart_item(input opcode_e op, input logic [2:0] addr,
                                   input logic [7:0] wdata, input logic [7:0] rbyte,
                                   input logic [3:0] lines, output result_t res);
    logic       dlab;
    logic [7:0] new_msr;
    res = '0;
    dlab = lcr_q[LCR_DLAB_BIT];
    case (op)
      OP_WRITE: begin
        case (addr)
          ADDR_DATA: begin
            if (dlab) begin
              div_latch[7:0] = wdata;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte = wdata;
              thre_pending = 1'b1;
              lsr_q = lsr_q | LSR_TX_EMPTY;
              refresh_ident();
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              div_latch[15:8] = wdata;
            end else begin
              ier_q = wdata[3:0];
              if (lsr_q[LSR_THRE_BIT]) thre_pending = 1'b1;
              refresh_ident();
            end
          end
          ADDR_LCR: lcr_q = wdata;
          ADDR_MCR: mcr_q = wdata[4:0];
          ADDR_SCR: scr_q = wdata;
          default: ;
        endcase
      end
      OP_READ: begin
        case (addr)
          ADDR_DATA: begin
            if (dlab) begin
              res.read_data = div_latch[7:0];
            end else begin
              res.read_data = rx_buf;
              lsr_q = lsr_q & ~LSR_DR_BI;
              refresh_ident();
            end
          end
          ADDR_IER: res.read_data = dlab ? div_latch[15:8] : {4'h0, ier_q};
          ADDR_IIR: begin
            res.read_data = {5'b0, iir_q};
            if (iir_q == IID_THRE) thre_pending = 1'b0;
            refresh_ident();
          end
          ADDR_LCR: res.read_data = lcr_q;
          ADDR_MCR: res.read_data = {3'b0, mcr_q};
          ADDR_LSR: res.read_data = lsr_q;
          ADDR_MSR: begin
            if (mcr_q[MCR_LOOP_BIT]) begin
              // OUT2 -> DCD, OUT1 -> RI, DTR -> DSR, RTS -> CTS; nothing cleared
              res.read_data = {mcr_q[3], mcr_q[2], mcr_q[0], mcr_q[1], 4'h0};
            end else begin
              res.read_data = msr_q;
              msr_q[3:0] = 4'h0;
              modem_chg_seen = 1'b0;
              refresh_ident();
            end
          end
          default: res.read_data = scr_q;
        endcase
      end
      OP_RX: begin
        // Overrun: drop the byte while data is still unread
        if (!lsr_q[LSR_DR_BIT]) begin
          rx_buf = rbyte;
          lsr_q[LSR_DR_BIT] = 1'b1;
          refresh_ident();
          res.rx_accepted = 1'b1;
        end
      end
      default: begin
        new_msr = {lines, 4'h0};
        new_msr[3] = lines[3] != msr_q[7];
        new_msr[2] = !lines[2] && msr_q[6];
        new_msr[1] = lines[1] != msr_q[5];
        new_msr[0] = lines[0] != msr_q[4];
        msr_q = new_msr;
        modem_chg_seen = 1'b1;
        refresh_ident();
      end
    endcase
    res.irq_level = iir_q != IID_NONE;
    res.rts_out = mcr_q[1];
    res.dtr_out = mcr_q[0];
    res.baud_divisor = div_latch;
    res.line_format = lcr_q;
  endtask

  // Compare the result word first, then queue the prediction for the input word
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    result_t pred;
    if (!rst_ni) begin
      div_latch = 16'h0;
      rx_buf = 8'h0;
      ier_q = 4'h0;
      iir_q = IID_NONE;
      lcr_q = 8'h0;
      mcr_q = 5'h0;
      lsr_q = LSR_RESET;
      msr_q = MSR_RESET;
      scr_q = 8'h0;
      thre_pending = 1'b0;
      modem_chg_seen = 1'b0;
      expected_results.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = expected_results.pop_front();
          got.read_data    = m_axis_tdata[7:0];
          got.irq_level    = m_axis_tdata[8];
          got.tx_valid     = m_axis_tdata[9];
          got.tx_byte      = m_axis_tdata[17:10];
          got.rx_accepted  = m_axis_tdata[18];
          got.rts_out      = m_axis_tdata[19];
          got.dtr_out      = m_axis_tdata[20];
          got.baud_divisor = m_axis_tdata[36:21];
          got.line_format  = m_axis_tdata[44:37];
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
          if (got.irq_level !== want.irq_level)
            report_mismatch("irq_level", 16'(got.irq_level), 16'(want.irq_level));
          if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
          if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
          if (got.rx_accepted !== want.rx_accepted)
            report_mismatch("rx_accepted", 16'(got.rx_accepted), 16'(want.rx_accepted));
          if (got.rts_out !== want.rts_out)
            report_mismatch("rts_out", 16'(got.rts_out), 16'(want.rts_out));
          if (got.dtr_out !== want.dtr_out)
            report_mismatch("dtr_out", 16'(got.dtr_out), 16'(want.dtr_out));
          if (got.baud_divisor !== want.baud_divisor)
            report_mismatch("baud_divisor", got.baud_divisor, want.baud_divisor);
          if (got.line_format !== want.line_format)
            report_mismatch("line_format", 16'(got.line_format), 16'(want.line_format));
          if (m_axis_tdata[47:45] !== 3'b000)
            report_mismatch("padding", 16'(m_axis_tdata[47:45]), 16'h0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_uart_item(opcode_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[10:3],
                          s_axis_tdata[18:11], s_axis_tdata[22:19], pred);
        expected_results.push_back(pred);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: bench/uart_16450_register_file_top_tb.sv
module uart_16450_register_file_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import uartrf_pkg::*;

  localparam int RANDOM_WORDS = 950;
  localparam int QUIET_WORDS  = 150;
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [1:0]            s_axis_tuser = 2'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int  fail_count;
  int  pending;
  bit  quiet = 1'b0;
  int  ready_hold = 0;
  int  cycle_count = 0;

  always #4 clk_i = ~clk_i;

  uart_16450_register_file_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  uart_16450_register_file_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Stall the result side in short random bursts
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      m_axis_tready <= 1'b0;
      ready_hold--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one word, with an optional idle burst before it, and hold until taken
  task automatic send_word(input opcode_e op, input logic [2:0] addr, input logic [7:0] wdata,
                           input logic [7:0] rbyte, input logic [3:0] lines);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, lines, rbyte, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic bus_write(input logic [2:0] addr, input logic [7:0] wdata);
    send_word(OP_WRITE, addr, wdata, 8'h00, 4'h0);
  endtask

  task automatic bus_read(input logic [2:0] addr);
    send_word(OP_READ, addr, 8'h00, 8'h00, 4'h0);
  endtask

  // Mostly register traffic, with line events mixed in; every field random
  task automatic random_word();
    int       pick;
    opcode_e  op;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_WRITE;
    else if (pick < 70) op = OP_READ;
    else if (pick < 85) op = OP_RX;
    else                op = OP_MODEM;
    send_word(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Power-on values
    bus_read(ADDR_IIR);
    bus_read(ADDR_LSR);
    bus_read(ADDR_MSR);
    // Divisor latch with its low byte all ones and its high byte zero
    bus_write(ADDR_LCR, 8'h80);
    bus_write(ADDR_DATA, 8'hFF);
    bus_write(ADDR_IER, 8'h00);
    bus_read(ADDR_DATA);
    bus_read(ADDR_IER);
    bus_write(ADDR_LCR, 8'h03);
    // Enable everything, then clear the transmit-empty interrupt by reading it
    bus_write(ADDR_IER, 8'hFF);
    bus_read(ADDR_IIR);
    bus_write(ADDR_DATA, 8'h00);
    bus_write(ADDR_DATA, 8'hFF);
    // Receive, overrun, then drain
    send_word(OP_RX, 3'd0, 8'h00, 8'hFF, 4'h0);
    send_word(OP_RX, 3'd0, 8'h00, 8'h00, 4'h0);
    bus_read(ADDR_DATA);
    // Modem lines all high, then all low so RI falls
    send_word(OP_MODEM, 3'd0, 8'h00, 8'h00, 4'hF);
    send_word(OP_MODEM, 3'd0, 8'h00, 8'h00, 4'h0);
    bus_read(ADDR_MSR);
    // Loopback modem status
    bus_write(ADDR_MCR, 8'hFF);
    bus_read(ADDR_MSR);
    bus_write(ADDR_MCR, 8'h00);
    // Writes to read-only offsets are dropped; the scratch register is written and read back
    bus_write(ADDR_IIR, 8'hFF);
    bus_write(ADDR_LSR, 8'hFF);
    bus_write(ADDR_MSR, 8'hFF);
    bus_write(ADDR_SCR, 8'hFF);
    bus_read(ADDR_SCR);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      random_word();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then let the output stage settle
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
